// File: hdl/contour_trace_marker_defines.svh
// ----------------------------------------------------------------------------
// contour_trace_marker assertion macros
// shared property wrappers for the port checker
// ----------------------------------------------------------------------------
`ifndef CONTOUR_TRACE_MARKER_DEFINES_SVH
`define CONTOUR_TRACE_MARKER_DEFINES_SVH

// same-cycle implication
`define CTM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CTM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/ctm_pkg.sv
// ----------------------------------------------------------------------------
// ctm_pkg
// shared types, constants and direction tables of the contour tracer
// ----------------------------------------------------------------------------
`default_nettype none

package ctm_pkg;

  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;
  localparam int COORD_W    = $clog2(MAX_WIDTH);
  localparam int ADDR_W     = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int DIM_W      = 7;
  localparam int GRAY_W     = 8;
  localparam int DIR_W      = 3;
  localparam int CFG_IDX_W  = 1;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_RUN   = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 1'b1;

  localparam logic [GRAY_W-1:0] GRAY_WHITE = 8'd255;
  localparam logic [GRAY_W-1:0] GRAY_BLACK = 8'd0;
  localparam logic [DIR_W-1:0]  DIR_FIRST  = 3'd7;
  localparam logic [DIR_W-1:0]  DIR_LAST_K = 3'd7;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [5:0]         col;
    logic [5:0]         row;
    logic [GRAY_W-1:0]  gray_in;
  } in_item_t;

  typedef struct packed {
    logic               marked;
    logic [GRAY_W-1:0]  gray_out;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_INIT_CLR,
    ST_IDLE,
    ST_READ,
    ST_RUN_CLR,
    ST_SCAN_LEFT,
    ST_SCAN_CUR,
    ST_SCAN_CHK,
    ST_SCAN_ADV,
    ST_T_MARK,
    ST_T_PROBE,
    ST_T_EVAL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic in_fire;
    logic load_zero;
    logic load_read;
    logic clr_step;
    logic scan_init;
    logic rd_left;
    logic rd_cur;
    logic scan_next;
    logic trace_init;
    logic mark_cur;
    logic probe;
    logic k_next;
    logic move;
  } ctl_t;

  typedef struct packed {
    logic out_valid;
    logic clr_last;
    logic scan_empty;
    logic scan_last;
    logic hit;
    logic nb_inside;
    logic nb_free;
    logic k_last;
    logic at_start;
  } sts_t;

  function automatic logic signed [1:0] step_dx(input logic [DIR_W-1:0] d);
    logic signed [1:0] r;
    unique case (d)
      3'd0, 3'd1, 3'd7: r = -2'sd1;
      3'd2, 3'd6:       r = 2'sd0;
      default:          r = 2'sd1;
    endcase
    return r;
  endfunction

  function automatic logic signed [1:0] step_dy(input logic [DIR_W-1:0] d);
    logic signed [1:0] r;
    unique case (d)
      3'd0, 3'd4:       r = 2'sd0;
      3'd1, 3'd2, 3'd3: r = -2'sd1;
      default:          r = 2'sd1;
    endcase
    return r;
  endfunction

  function automatic logic [DIR_W-1:0] next_start(input logic [DIR_W-1:0] d);
    logic [DIR_W-1:0] r;
    unique case (d)
      3'd0, 3'd7: r = 3'd1;
      3'd1, 3'd2: r = 3'd3;
      3'd3, 3'd4: r = 3'd5;
      default:    r = 3'd7;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hdl/contour_trace_marker.sv
// ----------------------------------------------------------------------------
// contour_trace_marker
// gray frame store with border scan and neighbor contour trace
//
// channel   direction  handshake                  payload
// in        input      in_valid / in_ready        in_item  (cmd, col, row, gray_in)
// out       output     out_valid / out_ready      out_item (marked, gray_out)
// cfg       input      cfg_we                     cfg_idx, cfg_wdata
//
// write and unused commands: result registered at the accept edge
// read: through the registered read ports of the frame and mark stores
// run: mark clearing pass, then left read, current read and check per scanned pixel;
//   per trace: mark, probe, evaluate for in-frame probes, resume scan; final done state
// after reset a mark clearing pass over all 4096 entries runs with in_ready low
// in_ready also waits while a finished result is stalled and not being taken
// ----------------------------------------------------------------------------
`default_nettype none

module contour_trace_marker (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [ctm_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [ctm_pkg::DIM_W-1:0]      cfg_wdata,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  ctm_pkg::in_item_t                   in_item,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output ctm_pkg::out_item_t                  out_item
);

  ctm_pkg::ctl_t ctl;
  ctm_pkg::sts_t sts;

  ctm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_cmd    (in_item.cmd),
    .out_ready (out_ready),
    .sts       (sts),
    .in_ready  (in_ready),
    .ctl       (ctl)
  );

  ctm_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_item   (in_item),
    .out_ready (out_ready),
    .ctl       (ctl),
    .sts       (sts),
    .out_item  (out_item),
    .out_valid (out_valid)
  );

endmodule

`default_nettype wire

// File: hdl/ctm_ctrl.sv
// ----------------------------------------------------------------------------
// ctm_ctrl
// sequencer for item handling, mark clearing, frame scan and border trace
// ----------------------------------------------------------------------------
`default_nettype none

module ctm_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire logic [1:0]    in_cmd,
  input  wire logic          out_ready,
  input  ctm_pkg::sts_t      sts,
  output logic               in_ready,
  output ctm_pkg::ctl_t      ctl
);

  ctm_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ctm_pkg::ST_INIT_CLR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ctm_pkg::ST_INIT_CLR: begin
        ctl.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_next = ctm_pkg::ST_IDLE;
        end
      end
      ctm_pkg::ST_IDLE: begin
        in_ready = !sts.out_valid || out_ready;
        if (in_valid && in_ready) begin
          ctl.in_fire = 1'b1;
          if (in_cmd == ctm_pkg::CMD_READ) begin
            state_next = ctm_pkg::ST_READ;
          end else if (in_cmd == ctm_pkg::CMD_RUN) begin
            state_next = ctm_pkg::ST_RUN_CLR;
          end else begin
            ctl.load_zero = 1'b1;
          end
        end
      end
      ctm_pkg::ST_READ: begin
        ctl.load_read = 1'b1;
        state_next    = ctm_pkg::ST_IDLE;
      end
      ctm_pkg::ST_RUN_CLR: begin
        ctl.clr_step = 1'b1;
        if (sts.clr_last) begin
          if (sts.scan_empty) begin
            state_next = ctm_pkg::ST_DONE;
          end else begin
            ctl.scan_init = 1'b1;
            state_next    = ctm_pkg::ST_SCAN_LEFT;
          end
        end
      end
      ctm_pkg::ST_SCAN_LEFT: begin
        ctl.rd_left = 1'b1;
        state_next  = ctm_pkg::ST_SCAN_CUR;
      end
      ctm_pkg::ST_SCAN_CUR: begin
        ctl.rd_cur = 1'b1;
        state_next = ctm_pkg::ST_SCAN_CHK;
      end
      ctm_pkg::ST_SCAN_CHK: begin
        if (sts.hit) begin
          ctl.trace_init = 1'b1;
          state_next     = ctm_pkg::ST_T_MARK;
        end else begin
          ctl.scan_next = 1'b1;
          state_next    = sts.scan_last ? ctm_pkg::ST_DONE : ctm_pkg::ST_SCAN_LEFT;
        end
      end
      ctm_pkg::ST_SCAN_ADV: begin
        ctl.scan_next = 1'b1;
        state_next    = sts.scan_last ? ctm_pkg::ST_DONE : ctm_pkg::ST_SCAN_LEFT;
      end
      ctm_pkg::ST_T_MARK: begin
        ctl.mark_cur = 1'b1;
        state_next   = ctm_pkg::ST_T_PROBE;
      end
      ctm_pkg::ST_T_PROBE: begin
        if (sts.nb_inside) begin
          ctl.probe  = 1'b1;
          state_next = ctm_pkg::ST_T_EVAL;
        end else if (sts.k_last) begin
          state_next = ctm_pkg::ST_SCAN_ADV;
        end else begin
          ctl.k_next = 1'b1;
        end
      end
      ctm_pkg::ST_T_EVAL: begin
        if (sts.nb_free) begin
          ctl.move   = 1'b1;
          state_next = sts.at_start ? ctm_pkg::ST_SCAN_ADV : ctm_pkg::ST_T_MARK;
        end else if (sts.k_last) begin
          state_next = ctm_pkg::ST_SCAN_ADV;
        end else begin
          ctl.k_next = 1'b1;
          state_next = ctm_pkg::ST_T_PROBE;
        end
      end
      ctm_pkg::ST_DONE: begin
        ctl.load_zero = 1'b1;
        state_next    = ctm_pkg::ST_IDLE;
      end
      default: begin
        state_next = ctm_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hdl/ctm_dp.sv
// ----------------------------------------------------------------------------
// ctm_dp
// frame store, mark map, scan and trace coordinates, result register
// ----------------------------------------------------------------------------
`default_nettype none

module ctm_dp (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [ctm_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  wire logic [ctm_pkg::DIM_W-1:0]       cfg_wdata,
  input  ctm_pkg::in_item_t                    in_item,
  input  wire logic                            out_ready,
  input  ctm_pkg::ctl_t                        ctl,
  output ctm_pkg::sts_t                        sts,
  output ctm_pkg::out_item_t                   out_item,
  output logic                                 out_valid
);

  localparam int CW = ctm_pkg::COORD_W;
  localparam int AW = ctm_pkg::ADDR_W;
  localparam int DW = ctm_pkg::DIM_W;

  logic [ctm_pkg::GRAY_W-1:0] gray_mem [0:(1 << AW) - 1];
  logic                       mark_mem [0:(1 << AW) - 1];

  logic [DW-1:0]  frame_width, frame_height;
  logic [DW-1:0]  eff_w, eff_h;
  logic [AW-1:0]  clr_addr;
  logic [CW-1:0]  scan_x, scan_y, cur_x, cur_y, start_x, start_y;
  logic [2:0]     dir, k;
  logic [ctm_pkg::GRAY_W-1:0] left_gray, gray_rd;
  logic           mark_rd;

  logic [2:0]        d;
  logic signed [7:0] nxs, nys;
  logic [CW-1:0]     nx, ny;
  logic [AW-1:0]     gray_raddr, mark_raddr, mark_waddr;
  logic              mark_we, mark_wdata, y_wrap;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= DW'(ctm_pkg::MAX_WIDTH);
      frame_height <= DW'(ctm_pkg::MAX_HEIGHT);
    end else if (cfg_we) begin
      if (cfg_idx == ctm_pkg::CFG_WIDTH) begin
        frame_width <= cfg_wdata;
      end else begin
        frame_height <= cfg_wdata;
      end
    end
  end

  assign eff_w = (frame_width > DW'(ctm_pkg::MAX_WIDTH)) ? DW'(ctm_pkg::MAX_WIDTH) : frame_width;
  assign eff_h = (frame_height > DW'(ctm_pkg::MAX_HEIGHT)) ? DW'(ctm_pkg::MAX_HEIGHT)
                                                         : frame_height;

  // neighbor of the trace cursor in the direction under test
  assign d   = dir - k;
  assign nxs = $signed({2'b00, cur_x}) + 8'(ctm_pkg::step_dx(d));
  assign nys = $signed({2'b00, cur_y}) + 8'(ctm_pkg::step_dy(d));
  assign nx  = nxs[CW-1:0];
  assign ny  = nys[CW-1:0];

  assign y_wrap = ({1'b0, scan_y} + DW'(1)) == eff_h;

  always_comb begin
    sts.out_valid  = out_valid;
    sts.clr_last   = &clr_addr;
    sts.scan_empty = (eff_w < DW'(2)) || (eff_h == '0);
    sts.scan_last  = y_wrap && (({1'b0, scan_x} + DW'(1)) == eff_w);
    sts.hit        = (left_gray == ctm_pkg::GRAY_WHITE) && (gray_rd == ctm_pkg::GRAY_BLACK)
                     && !mark_rd;
    sts.nb_inside  = !nxs[7] && !nys[7] && (nxs[DW-1:0] < eff_w) && (nys[DW-1:0] < eff_h);
    sts.nb_free    = !mark_rd && (gray_rd == ctm_pkg::GRAY_BLACK);
    sts.k_last     = (k == ctm_pkg::DIR_LAST_K);
    sts.at_start   = (nx == start_x) && (ny == start_y);
  end

  always_comb begin
    priority if (ctl.probe) begin
      gray_raddr = {ny, nx};
    end else if (ctl.rd_left) begin
      gray_raddr = {scan_y, scan_x - CW'(1)};
    end else if (ctl.rd_cur) begin
      gray_raddr = {scan_y, scan_x};
    end else begin
      gray_raddr = {in_item.row, in_item.col};
    end
    priority if (ctl.probe) begin
      mark_raddr = {ny, nx};
    end else if (ctl.rd_cur) begin
      mark_raddr = {scan_y, scan_x};
    end else begin
      mark_raddr = {in_item.row, in_item.col};
    end
    mark_we    = ctl.clr_step || ctl.mark_cur;
    mark_waddr = ctl.clr_step ? clr_addr : {cur_y, cur_x};
    mark_wdata = !ctl.clr_step;
  end

  always_ff @(posedge clk) begin
    if (ctl.in_fire && (in_item.cmd == ctm_pkg::CMD_WRITE)) begin
      gray_mem[{in_item.row, in_item.col}] <= in_item.gray_in;
    end
    gray_rd <= gray_mem[gray_raddr];
  end

  always_ff @(posedge clk) begin
    if (mark_we) begin
      mark_mem[mark_waddr] <= mark_wdata;
    end
    mark_rd <= mark_mem[mark_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (ctl.clr_step) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.scan_init) begin
      scan_x <= CW'(1);
      scan_y <= '0;
    end else if (ctl.scan_next) begin
      if (y_wrap) begin
        scan_y <= '0;
        scan_x <= scan_x + CW'(1);
      end else begin
        scan_y <= scan_y + CW'(1);
      end
    end
    if (ctl.rd_cur) begin
      left_gray <= gray_rd;
    end
    if (ctl.trace_init) begin
      cur_x   <= scan_x;
      cur_y   <= scan_y;
      start_x <= scan_x;
      start_y <= scan_y;
      dir     <= ctm_pkg::DIR_FIRST;
    end else if (ctl.move) begin
      cur_x <= nx;
      cur_y <= ny;
      dir   <= ctm_pkg::next_start(d);
    end
    if (ctl.mark_cur) begin
      k <= '0;
    end else if (ctl.k_next) begin
      k <= k + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_read) begin
      out_item <= '{marked: mark_rd, gray_out: gray_rd};
    end else if (ctl.load_zero) begin
      out_item <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.load_read || ctl.load_zero) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// File: hdl/ctm_checker.sv
// ----------------------------------------------------------------------------
// ctm_checker
// port-level timing checks of the contour tracer
// ----------------------------------------------------------------------------
`default_nettype none
`include "contour_trace_marker_defines.svh"

module ctm_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input ctm_pkg::in_item_t        in_item,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input ctm_pkg::out_item_t       out_item
);

  logic in_fire;
  assign in_fire = in_valid && in_ready;

  `CTM_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_item), "stalled item dropped or changed")
  `CTM_ASSERT_NXT(a_write_result, in_fire && in_item.cmd == ctm_pkg::CMD_WRITE, out_valid, "write item without result")
  `CTM_ASSERT_IMP(a_read_result, in_fire && in_item.cmd == ctm_pkg::CMD_READ, ##2 out_valid, "read item result late")
  `CTM_ASSERT_NXT(a_run_busy, in_fire && in_item.cmd == ctm_pkg::CMD_RUN, !in_ready && !out_valid, "run did not hold off items")

endmodule

bind contour_trace_marker ctm_checker u_ctm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);

`default_nettype wire

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// contour tracer testbench
// loads gray frames, runs the border scan and reads back marks and pixels;
// every result is checked against a cycle-free software copy of the tracer
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

class trace_scoreboard;
  logic [7:0] gray_mem [4096];
  bit mark_mem [4096];
  int frame_w = 64;
  int frame_h = 64;
  ctm_pkg::out_item_t want_q[$];
  int errors = 0;
  int runs = 0;
  int reads = 0;
  int marked_reads = 0;
  int dx_tab[8] = '{-1, -1, 0, 1, 1, 1, 0, -1};
  int dy_tab[8] = '{0, -1, -1, -1, 0, 1, 1, 1};
  int start_tab[8] = '{1, 3, 3, 5, 5, 7, 7, 1};

  function void set_dim(bit idx, int v);
    if (idx == ctm_pkg::CFG_WIDTH) frame_w = v & 127;
    else frame_h = v & 127;
  endfunction

  function void follow_border(int sx, int sy, int fw, int fh);
    int x, y, nx, ny, d, k, dir;
    bit moved;
    x = sx;
    y = sy;
    dir = 7;
    forever begin
      mark_mem[y * 64 + x] = 1;
      moved = 0;
      for (k = 0; k < 8 && !moved; k++) begin
        d = (dir + 8 - k) & 7;
        nx = x + dx_tab[d];
        ny = y + dy_tab[d];
        if (nx >= 0 && ny >= 0 && nx < fw && ny < fh) begin
          if (!mark_mem[ny * 64 + nx] && gray_mem[ny * 64 + nx] == 8'd0) begin
            x = nx;
            y = ny;
            dir = start_tab[d];
            moved = 1;
          end
        end
      end
      if (!moved || (x == sx && y == sy)) break;
    end
  endfunction

  function void scan_frame();
    int fw, fh, x, y;
    fw = frame_w > 64 ? 64 : frame_w;
    fh = frame_h > 64 ? 64 : frame_h;
    foreach (mark_mem[i]) mark_mem[i] = 0;
    for (x = 1; x < fw; x++)
      for (y = 0; y < fh; y++)
        if (gray_mem[y * 64 + x - 1] == 8'd255 && gray_mem[y * 64 + x] == 8'd0 &&
            !mark_mem[y * 64 + x])
          follow_border(x, y, fw, fh);
  endfunction

  function void note(ctm_pkg::in_item_t it);
    ctm_pkg::out_item_t r;
    int a;
    r = '0;
    a = it.row * 64 + it.col;
    case (it.cmd)
      ctm_pkg::CMD_WRITE: gray_mem[a] = it.gray_in;
      ctm_pkg::CMD_RUN: begin
        scan_frame();
        runs++;
      end
      ctm_pkg::CMD_READ: begin
        r.marked = mark_mem[a];
        r.gray_out = gray_mem[a];
        reads++;
        if (mark_mem[a]) marked_reads++;
      end
      default: ;
    endcase
    want_q.push_back(r);
  endfunction

  function void check(ctm_pkg::out_item_t got);
    ctm_pkg::out_item_t w;
    if (want_q.size() == 0) begin
      $error("unexpected result item %h", got);
      errors++;
      return;
    end
    w = want_q.pop_front();
    if (got.marked !== w.marked) begin
      $error("marked: expected %0d actual %0d", w.marked, got.marked);
      errors++;
    end
    if (got.gray_out !== w.gray_out) begin
      $error("gray_out: expected %0d actual %0d", w.gray_out, got.gray_out);
      errors++;
    end
  endfunction
endclass

module tb;

  localparam int STALL_LIMIT = 100000;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [ctm_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
  logic [ctm_pkg::DIM_W-1:0] cfg_wdata = '0;
  logic in_valid = 0;
  logic in_ready;
  ctm_pkg::in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 0;
  ctm_pkg::out_item_t out_item;

  trace_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;

  contour_trace_marker uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
    if (!rst) begin
      if (out_valid && out_ready) sb.check(out_item);
      if ((out_valid && out_ready) || (in_valid && in_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic send_item(logic [1:0] cmd, int col, int row, int gray);
    ctm_pkg::in_item_t it;
    it.cmd = cmd;
    it.col = 6'(col);
    it.row = 6'(row);
    it.gray_in = 8'(gray);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_item <= it;
    do @(posedge clk); while (!in_ready);
    sb.note(it);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.want_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_frame(int fw, int fh);
    drain();
    cfg_we <= 1;
    cfg_idx <= ctm_pkg::CFG_WIDTH;
    cfg_wdata <= ctm_pkg::DIM_W'(fw);
    @(posedge clk);
    sb.set_dim(ctm_pkg::CFG_WIDTH, fw);
    cfg_idx <= ctm_pkg::CFG_HEIGHT;
    cfg_wdata <= ctm_pkg::DIM_W'(fh);
    @(posedge clk);
    sb.set_dim(ctm_pkg::CFG_HEIGHT, fh);
    cfg_we <= 0;
  endtask

  function automatic int pick_gray();
    int r;
    r = $urandom_range(9);
    if (r < 4) return 0;
    if (r < 8) return 255;
    return $urandom_range(255);
  endfunction

  initial begin
    int fw, fh, x, y, n;
    repeat (3) @(posedge clk);
    rst <= 0;
    set_frame(64, 8);
    // fill rows 0-7 and columns 0-1 so no frame or read touches an unwritten pixel
    for (y = 0; y < 64; y++)
      for (x = 0; x < (y < 8 ? 64 : 2); x++)
        send_item(ctm_pkg::CMD_WRITE, x, y,
                  (x + y) % 3 == 0 ? $urandom_range(255) : pick_gray());
    // directed
    send_item(ctm_pkg::CMD_WRITE, 0, 0, 255);
    send_item(ctm_pkg::CMD_WRITE, 1, 0, 0);
    send_item(ctm_pkg::CMD_WRITE, 62, 63, 255);
    send_item(ctm_pkg::CMD_WRITE, 63, 63, 0);
    send_item(ctm_pkg::CMD_WRITE, 63, 0, 8'hAA);
    send_item(ctm_pkg::CMD_WRITE, 0, 63, 8'h55);
    send_item(CMD_UNUSED, 63, 63, 255);
    send_item(ctm_pkg::CMD_RUN, 0, 0, 0);
    send_item(ctm_pkg::CMD_READ, 0, 0, 0);
    send_item(ctm_pkg::CMD_READ, 1, 0, 0);
    send_item(ctm_pkg::CMD_READ, 63, 63, 0);
    send_item(ctm_pkg::CMD_READ, 62, 63, 0);
    send_item(ctm_pkg::CMD_READ, 63, 0, 0);
    send_item(ctm_pkg::CMD_READ, 0, 63, 0);
    send_item(CMD_UNUSED, 0, 0, 0);
    set_frame(2, 1);
    send_item(ctm_pkg::CMD_RUN, 0, 0, 0);
    send_item(ctm_pkg::CMD_READ, 1, 0, 0);
    set_frame(1, 64);
    send_item(ctm_pkg::CMD_RUN, 0, 0, 0);
    send_item(ctm_pkg::CMD_READ, 1, 0, 0);
    set_frame(64, 0);
    send_item(ctm_pkg::CMD_RUN, 0, 0, 0);
    send_item(ctm_pkg::CMD_READ, 63, 63, 0);
    set_frame(127, 8);
    send_item(ctm_pkg::CMD_RUN, 0, 0, 0);
    send_item(ctm_pkg::CMD_READ, 63, 7, 0);
    set_frame(2, 127);
    send_item(ctm_pkg::CMD_RUN, 0, 0, 0);
    send_item(ctm_pkg::CMD_READ, 1, 63, 0);

    // random phases: frame setting, image edits, one run, read back
    for (int ph = 0; ph < 17; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 52; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 52; end
        default: begin send_idle_pct = 13; recv_stall_pct = 13; end
      endcase
      case (ph % 6)
        0: begin fw = 64; fh = 8; end
        1: begin fw = 2; fh = 1; end
        2: begin
          if (ph % 12 == 2) begin
            fw = $urandom_range(65, 127);
            fh = $urandom_range(8);
          end else begin
            fw = $urandom_range(2);
            fh = $urandom_range(65, 127);
          end
        end
        default: begin fw = $urandom_range(4, 64); fh = $urandom_range(1, 8); end
      endcase
      set_frame(fw, fh);
      fw = fw > 64 ? 64 : (fw < 2 ? 2 : fw);
      fh = fh > 64 ? 64 : (fh < 1 ? 1 : fh);
      n = $urandom_range(8, 14);
      for (int i = 0; i < n; i++) begin
        x = $urandom_range(1, fw - 1);
        y = $urandom_range(fh - 1);
        case ($urandom_range(9))
          0: send_item(CMD_UNUSED, $urandom_range(63), $urandom_range(63),
                       $urandom_range(255));
          1: send_item(ctm_pkg::CMD_WRITE, $urandom_range(63), $urandom_range(63),
                       $urandom_range(255));
          2, 3, 4, 5: begin
            send_item(ctm_pkg::CMD_WRITE, x - 1, y, 255);
            send_item(ctm_pkg::CMD_WRITE, x, y, 0);
          end
          default: send_item(ctm_pkg::CMD_WRITE, x, y, pick_gray());
        endcase
      end
      if (ph == 5) drain();
      send_item(ctm_pkg::CMD_RUN, $urandom_range(63), $urandom_range(63),
                $urandom_range(255));
      n = $urandom_range(10, 16);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(3) == 0) begin
          if ($urandom_range(1) == 0)
            send_item(ctm_pkg::CMD_READ, $urandom_range(63), $urandom_range(7),
                      $urandom_range(255));
          else
            send_item(ctm_pkg::CMD_READ, $urandom_range(1), $urandom_range(63),
                      $urandom_range(255));
        end else begin
          send_item(ctm_pkg::CMD_READ, $urandom_range(fw - 1), $urandom_range(fh - 1), 0);
        end
      end
    end

    drain();
    repeat (20) @(posedge clk);
    $display("run covered %0d scans and %0d reads, %0d of them on marked pixels",
             sb.runs, sb.reads, sb.marked_reads);
    if (sb.errors == 0 && sb.want_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

// File: filelist.f
+incdir+hdl
hdl/ctm_pkg.sv
hdl/ctm_ctrl.sv
hdl/ctm_dp.sv
hdl/contour_trace_marker.sv
hdl/ctm_checker.sv
tb/tb.sv
